// ===== rtl/chash_pkg.sv =====
`default_nettype none

package chash_pkg;

	localparam int KEY_W    = 31;
	localparam int STATUS_W = 2;
	localparam int BUCKET_W = 8;

	// Opcodes of an input item.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef logic [STATUS_W-1:0] status_t;

	// Result codes.
	localparam status_t ST_INSERTED  = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_FOUND     = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	// The bucket index takes a reciprocal multiply and then a small multiply-subtract.
	localparam int MOD_STEPS   = 2;
	localparam int MOD_CNT_W   = 1;

	typedef struct packed {
		logic              opcode;
		logic [KEY_W-1:0]  key;
	} req_item_t;

	typedef struct packed {
		status_t              status;
		logic [BUCKET_W-1:0]  bucket;
	} rsp_item_t;

	typedef struct packed {
		logic    load;
		logic    mod_step;
		logic    fill_rd;
		logic    ins_wr;
		logic    scan_clr;
		logic    scan_step;
		logic    res_set;
		status_t res_code;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic is_search;
		logic full;
		logic hit;
		logic scan_end;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/chash_if.sv =====
`default_nettype none

interface chash_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/chash_ctrl.sv =====
`default_nettype none

module chash_ctrl
	import chash_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MOD    = 3'd1;
	localparam logic [2:0] S_RDFILL = 3'd2;
	localparam logic [2:0] S_FILL   = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_nxt = S_RDFILL;
				end
			end
			S_RDFILL: begin
				cmd.fill_rd = 1'b1;
				state_nxt   = S_FILL;
			end
			S_FILL: begin
				if (sts.is_search) begin
					cmd.scan_clr = 1'b1;
					state_nxt    = S_SCAN;
				end else if (sts.full) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_FULL;
					state_nxt    = S_DONE;
				end else begin
					cmd.ins_wr   = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_INSERTED;
					state_nxt    = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.hit) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_FOUND;
					state_nxt    = S_DONE;
				end else if (sts.scan_end) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_NOT_FOUND;
					state_nxt    = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/chash_dp.sv =====
`default_nettype none

module chash_dp
	import chash_pkg::*;
#(
	parameter int NUM_BUCKETS  = 8,
	parameter int BUCKET_DEPTH = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_item_t in_item,
	input  wire dp_cmd_t   cmd,
	output dp_sts_t        sts,
	output logic           out_valid,
	input  wire logic      out_ready,
	output rsp_item_t      out_item
);

	localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int ENTRIES = NUM_BUCKETS * BUCKET_DEPTH;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FW      = $clog2(BUCKET_DEPTH + 1);

	// The quotient of the key by the bucket count is (key * MOD_M) >> MOD_SH, exact for
	// every key of KEY_W bits since MOD_M is the reciprocal rounded up.
	localparam int MOD_SH = KEY_W + $clog2(NUM_BUCKETS);
	localparam int PROD_W = MOD_SH + BKT_W;
	localparam logic [63:0] MOD_M_W =
		((64'd1 << MOD_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
	localparam logic [KEY_W:0] MOD_M = MOD_M_W[KEY_W:0];

	localparam logic [BKT_W-1:0] NB_LO  = BKT_W'(NUM_BUCKETS);
	localparam logic [FW-1:0]    FULL_C = FW'(BUCKET_DEPTH);

	// Item registers.
	logic                  op_q;
	logic [KEY_W-1:0]      key_q;

	// Bucket index reduction.
	logic [PROD_W-1:0]     prod_q;
	logic [BKT_W-1:0]      quo_lo;
	logic [MOD_CNT_W-1:0]  mod_cnt_q;
	logic                  mod_last;
	logic [BKT_W-1:0]      bkt_q;
	logic [BKT_W-1:0]      bkt_nxt;

	// Fill counts: memory plus a valid bit per bucket.
	logic [FW-1:0]         fill_mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] fvalid_q;
	logic [FW-1:0]         fill_q;
	logic                  fvld_q;
	logic [FW-1:0]         fill_eff;
	logic [AW-1:0]         base_q;

	// Bucket storage and scan.
	logic [KEY_W-1:0]      store_mem [ENTRIES];
	logic [KEY_W-1:0]      rd_key_q;
	logic [FW-1:0]         rd_idx_q;
	logic                  pend_q;
	logic                  issue;

	// Result and output register.
	status_t               res_q;
	logic                  out_vld_q;
	status_t               out_status_q;
	logic [BKT_W-1:0]      out_bkt_q;

	// The remainder is below the bucket count, so only the low bits of the quotient
	// and of key - quotient * count are needed.
	assign quo_lo   = prod_q[MOD_SH +: BKT_W];
	assign bkt_nxt  = key_q[BKT_W-1:0] - quo_lo * NB_LO;
	assign mod_last = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_item.opcode;
			key_q <= in_item.key;
		end
		if (cmd.mod_step) begin
			prod_q <= PROD_W'(key_q) * PROD_W'(MOD_M);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q <= '0;
			bkt_q     <= '0;
		end else if (cmd.load) begin
			mod_cnt_q <= '0;
			bkt_q     <= '0;
		end else if (cmd.mod_step) begin
			mod_cnt_q <= mod_cnt_q + 1'b1;
			if (mod_last) begin
				bkt_q <= bkt_nxt;
			end
		end
	end

	assign fill_eff = fvld_q ? fill_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.fill_rd) begin
			fill_q <= fill_mem[bkt_q];
			base_q <= AW'(bkt_q * BUCKET_DEPTH);
		end
		if (cmd.ins_wr) begin
			fill_mem[bkt_q] <= fill_eff + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= '0;
			fvld_q   <= 1'b0;
		end else begin
			if (cmd.fill_rd) begin
				fvld_q <= fvalid_q[bkt_q];
			end
			if (cmd.ins_wr) begin
				fvalid_q[bkt_q] <= 1'b1;
			end
		end
	end

	// Scan reads one entry per cycle; the compare of each entry comes in the cycle after its read.
	assign issue = cmd.scan_step && (rd_idx_q != fill_eff);

	always_ff @(posedge clk) begin
		if (cmd.ins_wr) begin
			store_mem[base_q + AW'(fill_eff)] <= key_q;
		end
		if (issue) begin
			rd_key_q <= store_mem[base_q + AW'(rd_idx_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			pend_q   <= 1'b0;
		end else if (cmd.scan_clr) begin
			rd_idx_q <= '0;
			pend_q   <= 1'b0;
		end else if (cmd.scan_step) begin
			pend_q <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_q <= cmd.res_code;
		end
		if (cmd.out_load) begin
			out_status_q <= res_q;
			out_bkt_q    <= bkt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid       = out_vld_q;
	assign out_item.status = out_status_q;
	assign out_item.bucket = BUCKET_W'(out_bkt_q);

	assign sts.mod_done  = mod_last;
	assign sts.is_search = (op_q == OP_SEARCH);
	assign sts.full      = (fill_eff == FULL_C);
	assign sts.hit       = pend_q && (rd_key_q == key_q);
	assign sts.scan_end  = !pend_q && (rd_idx_q == fill_eff);
	assign sts.out_free  = !out_vld_q || out_ready;

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> (fill_eff != FULL_C))
		else $error("insert written into a full bucket");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (rd_idx_q <= fill_eff))
		else $error("scan index ran past the bucket fill");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || out_ready))
		else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

// ===== rtl/chained_hash_table.sv =====
// Channel  Dir  Payload                      Transfer
// req      in   opcode[0:0], key[30:0]       req.valid && req.ready
// rsp      out  status[1:0], bucket[7:0]     rsp.valid && rsp.ready
//
// A new item is taken only after the last result is loaded into the output register.
// A search scans the filled entries of its bucket, one entry per cycle, and stops on a hit;
// fill, the entry count of a bucket, is at most BUCKET_DEPTH. The bucket index takes a
// reciprocal multiply, then a multiply-subtract, ahead of the read of the fill count.
// Reset clears the per-bucket valid bits at once, so every bucket starts empty. A result
// waits in the output register while the next item is taken; the block holds a finished
// result in its last state only while that register is still full.
`default_nettype none

module chained_hash_table
	import chash_pkg::*;
#(
	parameter int NUM_BUCKETS  = 8,
	parameter int BUCKET_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	chash_if.sink     req,
	chash_if.source   rsp
);

	// Commands from the controller and status back to it.
	dp_cmd_t   cmd;
	dp_sts_t   sts;
	req_item_t in_item;
	rsp_item_t out_item;
	logic      in_ready;
	logic      out_valid;

	assign in_item   = req.data;
	assign req.ready = in_ready;

	// The controller sequences hashing, the fill read, the insert or the scan,
	// and the hand-off of the result into the output register.
	chash_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the key, the remainder unit, the fill counts, the
	// bucket memory and the output register.
	chash_dp #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.BUCKET_DEPTH (BUCKET_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.out_item  (out_item)
	);

	assign rsp.valid = out_valid;
	assign rsp.data  = out_item;

endmodule

`default_nettype wire

// ===== verif/tb_chained_hash_table.sv =====
`default_nettype none

// Self-checking bench for the chained hash table. Requests come from a queue that the
// stimulus process fills; a clocked driver offers them and a clocked monitor collects
// the results. A shadow copy of the table works out every result at the moment its
// request is accepted, and the monitor compares results against those, oldest first.
module tb_chained_hash_table;
	timeunit 1ns;
	timeprecision 1ps;

	import chash_pkg::*;

	localparam int NUM_BUCKETS  = 8;
	localparam int BUCKET_DEPTH = 16;

	localparam int CLK_HALF_NS = 2;
	// This leaves room beyond the slowest search.
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASE_ITEMS    = 450;
	localparam int PRESSURE_ITEMS = 30;
	// Each item costs its own work plus long random stalls on both sides; this limit is
	// several times the slowest correct run.
	localparam int unsigned CYCLE_LIMIT = 800000;

	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n;

	chash_if #(.T(req_item_t)) req_ch ();
	chash_if #(.T(rsp_item_t)) rsp_ch ();

	chained_hash_table #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.BUCKET_DEPTH (BUCKET_DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// Requests waiting to be offered, and results owed by the block in order.
	req_item_t pending_reqs[$];
	rsp_item_t owed_results[$];

	// Keys that the stimulus has tried to insert, so searches can aim at real entries.
	logic [KEY_W-1:0] known_keys[$];

	// Shadow of the table contents, updated in acceptance order.
	logic [KEY_W-1:0] shadow_keys [NUM_BUCKETS][BUCKET_DEPTH];
	int unsigned      shadow_count [NUM_BUCKETS];

	int          send_gap_pct;
	int          rsp_stall_pct;
	logic        hold_go;
	logic        rsp_hold;
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Applies one request to the shadow table and returns the result the block owes.
	// An insert lands behind the entries already in its bucket unless the bucket is
	// full; a search looks only at the filled entries of its bucket.
	function automatic rsp_item_t table_outcome(input req_item_t item);
		rsp_item_t   res;
		int unsigned b;
		b = item.key % NUM_BUCKETS;
		res.bucket = BUCKET_W'(b);
		if (item.opcode == OP_INSERT) begin
			if (shadow_count[b] >= BUCKET_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				shadow_keys[b][shadow_count[b]] = item.key;
				shadow_count[b]++;
				res.status = ST_INSERTED;
			end
		end else begin
			res.status = ST_NOT_FOUND;
			for (int i = 0; i < shadow_count[b]; i++) begin
				if (shadow_keys[b][i] == item.key)
					res.status = ST_FOUND;
			end
		end
		return res;
	endfunction

	task automatic push_req(input logic op, input logic [KEY_W-1:0] key);
		req_item_t it;
		it.opcode = op;
		it.key    = key;
		if (op == OP_INSERT)
			known_keys.push_back(key);
		pending_reqs.push_back(it);
	endtask

	// Random traffic. Inserts are kept to a minority so that the buckets fill up over
	// a good part of the run rather than in the first few hundred items. Most searches
	// aim at keys that were inserted, or at keys that share a bucket with one, so the
	// scan runs deep into populated buckets; the rest are near the largest key or random.
	task automatic queue_random_items(input int n);
		logic [KEY_W-1:0] key;
		int               pick;
		int               have;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(9);
			have = known_keys.size();
			key  = KEY_W'($urandom());
			if ($urandom_range(99) < 15) begin
				if (pick == 0)
					key = ($urandom_range(1) != 0) ? KEY_MAX : KEY_W'($urandom_range(7));
				else if (pick < 3 && have != 0)
					key = known_keys[$urandom_range(have - 1)];
				push_req(OP_INSERT, key);
			end else begin
				if (pick < 5 && have != 0)
					key = known_keys[$urandom_range(have - 1)];
				else if (pick < 8 && have != 0)
					key = known_keys[$urandom_range(have - 1)] ^ KEY_W'($urandom() << 3);
				else if (pick == 8)
					key = KEY_MAX - KEY_W'($urandom_range(7));
				push_req(OP_SEARCH, key);
			end
		end
	endtask

	// The sender pauses here until every request has gone in and every result is back.
	task automatic wait_for_drain();
		while (pending_reqs.size() != 0 || req_ch.valid || owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Driver: records accepted requests in the shadow table, then offers the next
	// request unless this cycle is chosen as an idle one. Valid is assigned once per
	// edge, so a back-to-back request keeps it high without a glitch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				owed_results.push_back(table_outcome(req_ch.data));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.data  <= pending_reqs.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest owed one and decides
	// ready for the next cycle, holding it low through a long hold-off when asked.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing owed: status %0d bucket %0d",
						rsp_ch.data.status, rsp_ch.data.bucket));
				end else begin
					want = owed_results.pop_front();
					if (rsp_ch.data.status != want.status)
						report_mismatch($sformatf("status %0d, wanted %0d (bucket %0d)",
							rsp_ch.data.status, want.status, want.bucket));
					if (rsp_ch.data.bucket != want.bucket)
						report_mismatch($sformatf("bucket %0d, wanted %0d",
							rsp_ch.data.bucket, want.bucket));
				end
			end
			rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Long hold-off on the result side, counted here, so that the block fills its
	// output register, holds its next result and has to stall incoming requests.
	initial begin
		rsp_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	// Run limit in case the block stops answering.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("ERROR: no progress within %0d cycles", CYCLE_LIMIT);
			$display("** chained_hash_table: FAILED **");
			$finish;
		end
	end

	initial begin
		int gap_by_phase [4];
		int stall_by_phase [4];
		gap_by_phase   = '{0, 48, 0, 7};
		stall_by_phase = '{0, 0, 48, 7};

		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		rsp_ch.ready  = 1'b0;
		send_gap_pct  = 0;
		rsp_stall_pct = 0;
		hold_go       = 1'b0;
		foreach (shadow_count[i])
			shadow_count[i] = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A search before anything is stored must miss. Key zero and
		// the largest key land in the first and last buckets. A duplicate insert and
		// keys that share a bucket but differ in high bits check the compare. Then
		// one bucket is filled to its depth, an insert into it must be dropped, and
		// the entry in its last slot must still be found.
		push_req(OP_SEARCH, 31'd5);
		push_req(OP_INSERT, 31'd0);
		push_req(OP_SEARCH, 31'd0);
		push_req(OP_INSERT, KEY_MAX);
		push_req(OP_SEARCH, KEY_MAX);
		push_req(OP_SEARCH, KEY_MAX - 31'd8);
		push_req(OP_INSERT, 31'd0);
		push_req(OP_SEARCH, 31'd8);
		for (int i = 0; i < BUCKET_DEPTH - 1; i++)
			push_req(OP_INSERT, KEY_W'(3 + NUM_BUCKETS * i));
		push_req(OP_INSERT, KEY_MAX - 31'd4);
		push_req(OP_INSERT, 31'd11);
		push_req(OP_SEARCH, KEY_MAX - 31'd4);
		wait_for_drain();

		// Pressure: results are held off for a long stretch while requests keep coming.
		hold_go = 1'b1;
		queue_random_items(PRESSURE_ITEMS);
		wait_for_drain();

		// Random phases: free running, idle sender, stalling receiver, and both.
		for (int p = 0; p < 4; p++) begin
			send_gap_pct  = gap_by_phase[p];
			rsp_stall_pct = stall_by_phase[p];
			queue_random_items(PHASE_ITEMS);
			wait_for_drain();
		end

		send_gap_pct  = 0;
		rsp_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (owed_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

		if (mismatches == 0)
			$display("** chained_hash_table: PASSED **");
		else
			$display("** chained_hash_table: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
